### hdl/range_missing_subset_sum_macros.svh
// Assertion macros used by the block's top module
`ifndef RANGE_MISSING_SUBSET_SUM_MACROS_SVH
`define RANGE_MISSING_SUBSET_SUM_MACROS_SVH
`define RMSS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RMSS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

### hdl/rmss_pkg.sv
`default_nettype none
package rmss_pkg;
    localparam int unsigned ValueWidth = 32;
    localparam int unsigned SumWidth   = 42;
    localparam int unsigned OutWidth   = 43;
    localparam int unsigned PosWidth   = 11;
    localparam logic        ActWrite   = 1'b0;
    localparam logic        ActQuery   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_LEAF,
        ST_WR_RD,
        ST_WR_PULL,
        ST_Q_STEP,
        ST_Q_RD,
        ST_Q_FOLD,
        ST_WALK_RD,
        ST_WALK,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

### hdl/rmss_tree_mem.sv
`default_nettype none
// Node memory: one word per (node, bucket), min and sum side by side.
module rmss_tree_mem #(
    parameter int unsigned AddrWidth = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [AddrWidth-1:0]                 waddr,
    input  wire logic [rmss_pkg::ValueWidth-1:0]      wmin,
    input  wire logic [rmss_pkg::SumWidth-1:0]        wsum,
    input  wire logic [AddrWidth-1:0]                 raddr_a,
    input  wire logic [AddrWidth-1:0]                 raddr_b,
    output logic      [rmss_pkg::ValueWidth-1:0]      rmin_a,
    output logic      [rmss_pkg::SumWidth-1:0]        rsum_a,
    output logic      [rmss_pkg::ValueWidth-1:0]      rmin_b,
    output logic      [rmss_pkg::SumWidth-1:0]        rsum_b
);
    localparam int unsigned Depth = 1 << AddrWidth;
    localparam int unsigned W = rmss_pkg::ValueWidth + rmss_pkg::SumWidth;
    logic [W-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wmin, wsum};
        end
        {rmin_a, rsum_a} <= mem[raddr_a];
        {rmin_b, rsum_b} <= mem[raddr_b];
    end
endmodule
`default_nettype wire

### hdl/range_missing_subset_sum.sv
// Write: one leaf word per bucket, then a read and a write per bucket at each
//   level up to the root. Query: each bucket is folded over the range level by
//   level towards the root, then the buckets are walked for the answer; an empty
//   range answers the cycle after it is taken.
// Throughput: one word at a time; input stalls until the word is done and any result taken.
// Reset: async, active low; a clearing pass over every word of the node memory follows.
`default_nettype none
`include "range_missing_subset_sum_macros.svh"
module range_missing_subset_sum #(
    parameter int unsigned ELEMENT_COUNT = 1024,
    parameter int unsigned BUCKET_COUNT  = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             action,
    input  wire logic [rmss_pkg::PosWidth-1:0]    position,
    input  wire logic [rmss_pkg::ValueWidth-1:0]  element_value,
    input  wire logic [rmss_pkg::PosWidth-1:0]    range_low,
    input  wire logic [rmss_pkg::PosWidth-1:0]    range_high,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [rmss_pkg::OutWidth-1:0]    smallest_missing
);
    localparam int unsigned NW = $clog2(2 * ELEMENT_COUNT);  // node index bits
    localparam int unsigned BW = $clog2(BUCKET_COUNT);
    localparam int unsigned AW = NW + BW;
    localparam int unsigned VW = rmss_pkg::ValueWidth;
    localparam int unsigned SW = rmss_pkg::SumWidth;
    localparam int unsigned OW = rmss_pkg::OutWidth;
    localparam logic [NW-1:0] LeafBase = NW'(ELEMENT_COUNT);

    rmss_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [NW-1:0] node_reg, node_next;     // write path node / query left bound
    logic [NW:0]   rnode_reg, rnode_next;   // query right bound (half-open, may reach 2*N)
    logic [BW-1:0] bkt_reg, bkt_next;
    logic [VW-1:0] val_reg, val_next;
    logic [NW:0]   lo_reg, lo_next, hi_reg, hi_next;
    logic [VW-1:0] mn_reg, mn_next;
    logic [SW-1:0] sm_reg, sm_next;
    logic          fl_reg, fl_next, fr_reg, fr_next;  // which folds pending
    logic [OW-1:0] ans_reg, ans_next;
    // per-bucket folded results (registers, read at bucket index during walk)
    logic [VW-1:0] bmin_reg [BUCKET_COUNT];
    logic [SW-1:0] bsum_reg [BUCKET_COUNT];
    logic          bwe;
    logic          lo_is;

    logic          we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [VW-1:0] wmin, rmin_a, rmin_b;
    logic [SW-1:0] wsum, rsum_a, rsum_b;
    logic [5:0]    tb;
    logic          tb_ok;

    rmss_tree_mem #(.AddrWidth(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wmin(wmin), .wsum(wsum),
        .raddr_a(raddr_a), .raddr_b(raddr_b),
        .rmin_a(rmin_a), .rsum_a(rsum_a), .rmin_b(rmin_b), .rsum_b(rsum_b)
    );

    // highest set bit of the written value
    always_comb
    begin
        tb    = '0;
        tb_ok = 1'b0;
        for (int k = 0; k < VW; k++)
        begin
            if (val_reg[k])
            begin
                tb    = 6'(k);
                tb_ok = 1'b1;
            end
        end
        tb_ok = tb_ok && (32'(tb) < BUCKET_COUNT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmss_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        rnode_reg <= rnode_next;
        bkt_reg   <= bkt_next;
        val_reg   <= val_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mn_reg    <= mn_next;
        sm_reg    <= sm_next;
        fl_reg    <= fl_next;
        fr_reg    <= fr_next;
        ans_reg   <= ans_next;
        if (bwe)
        begin
            bmin_reg[bkt_reg] <= mn_next;
            bsum_reg[bkt_reg] <= sm_next;
        end
    end

    assign in_stall         = (state_reg != rmss_pkg::ST_IDLE);
    assign out_valid        = (state_reg == rmss_pkg::ST_OUT);
    assign smallest_missing = ans_reg;
    assign lo_is = (ans_reg < (OW'(1) << (bkt_reg + 1))) || (32'(bkt_reg) + 1 >= 63);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        node_next  = node_reg;
        rnode_next = rnode_reg;
        bkt_next   = bkt_reg;
        val_next   = val_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mn_next    = mn_reg;
        sm_next    = sm_reg;
        fl_next    = fl_reg;
        fr_next    = fr_reg;
        ans_next   = ans_reg;
        bwe        = 1'b0;
        we         = 1'b0;
        waddr      = clr_reg;
        wmin       = '1;
        wsum       = '0;
        raddr_a    = {node_reg << 1, bkt_reg};
        raddr_b    = {(node_reg << 1) | NW'(1), bkt_reg};
        case (state_reg)
            rmss_pkg::ST_CLEAR:
            begin
                we       = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = rmss_pkg::ST_IDLE;
                end
            end
            rmss_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    bkt_next = '0;
                    if (action == rmss_pkg::ActWrite)
                    begin
                        val_next  = element_value;
                        node_next = LeafBase + NW'(position) - NW'(1);
                        if (position >= 11'd1 && 32'(position) <= ELEMENT_COUNT)
                        begin
                            state_next = rmss_pkg::ST_WR_LEAF;
                        end
                    end
                    else
                    begin
                        lo_next = (range_low < 11'd1) ? (NW+1)'(1) : (NW+1)'(range_low);
                        hi_next = (32'(range_high) > ELEMENT_COUNT)
                                  ? (NW+1)'(ELEMENT_COUNT) : (NW+1)'(range_high);
                        ans_next   = OW'(1);
                        state_next = rmss_pkg::ST_OUT;
                        if (!(range_low > range_high && range_low >= 11'd1
                              && 32'(range_high) <= ELEMENT_COUNT)
                            && !((range_low < 11'd1 ? 32'd1 : 32'(range_low))
                                 > (32'(range_high) > ELEMENT_COUNT ? ELEMENT_COUNT
                                    : 32'(range_high))))
                        begin
                            state_next = rmss_pkg::ST_Q_STEP;
                        end
                    end
                end
            end
            rmss_pkg::ST_WR_LEAF:
            begin
                // leaf word for each bucket, one per cycle
                we       = 1'b1;
                waddr    = {node_reg, bkt_reg};
                if (tb_ok && BW'(tb) == bkt_reg)
                begin
                    wmin = val_reg;
                    wsum = SW'(val_reg);
                end
                bkt_next = bkt_reg + BW'(1);
                if (32'(bkt_reg) == BUCKET_COUNT - 1)
                begin
                    bkt_next   = '0;
                    node_next  = node_reg >> 1;
                    state_next = rmss_pkg::ST_WR_RD;
                end
            end
            rmss_pkg::ST_WR_RD:
            begin
                state_next = rmss_pkg::ST_WR_PULL;
            end
            rmss_pkg::ST_WR_PULL:
            begin
                we         = 1'b1;
                waddr      = {node_reg, bkt_reg};
                wmin       = (rmin_a < rmin_b) ? rmin_a : rmin_b;
                wsum       = rsum_a + rsum_b;
                bkt_next   = bkt_reg + BW'(1);
                state_next = rmss_pkg::ST_WR_RD;
                if (32'(bkt_reg) == BUCKET_COUNT - 1)
                begin
                    bkt_next  = '0;
                    node_next = node_reg >> 1;
                    if (node_reg == NW'(1))
                    begin
                        state_next = rmss_pkg::ST_IDLE;
                    end
                end
            end
            rmss_pkg::ST_Q_STEP:
            begin
                // start bucket bkt_reg: reset bounds and accumulators
                node_next  = LeafBase + NW'(lo_reg) - NW'(1);
                rnode_next = (NW+1)'(LeafBase) + hi_reg;
                mn_next    = '1;
                sm_next    = '0;
                state_next = rmss_pkg::ST_Q_RD;
            end
            rmss_pkg::ST_Q_RD:
            begin
                raddr_a = {node_reg, bkt_reg};
                raddr_b = {NW'(rnode_reg - (NW+1)'(1)), bkt_reg};
                fl_next = node_reg[0];
                fr_next = rnode_reg[0];
                if ({1'b0, node_reg} < rnode_reg)
                begin
                    state_next = rmss_pkg::ST_Q_FOLD;
                end
                else
                begin
                    bwe        = 1'b1;
                    state_next = rmss_pkg::ST_WALK_RD;
                    if (32'(bkt_reg) != BUCKET_COUNT - 1)
                    begin
                        bkt_next   = bkt_reg + BW'(1);
                        state_next = rmss_pkg::ST_Q_STEP;
                    end
                    else
                    begin
                        bkt_next = '0;
                    end
                end
            end
            rmss_pkg::ST_Q_FOLD:
            begin
                // at most one left and one right node per level; when they
                // coincide only one side fires (l odd makes l+1 == r even)
                if (fl_reg)
                begin
                    if (rmin_a < mn_next)
                    begin
                        mn_next = rmin_a;
                    end
                    sm_next = sm_next + rsum_a;
                end
                if (fr_reg && !(fl_reg && ({1'b0, node_reg} + (NW+1)'(1)) == rnode_reg))
                begin
                    if (rmin_b < mn_next)
                    begin
                        mn_next = rmin_b;
                    end
                    sm_next = sm_next + rsum_b;
                end
                node_next  = NW'(({1'b0, node_reg} + (NW+1)'(fl_reg)) >> 1);
                rnode_next = (rnode_reg - (NW+1)'(fr_reg)) >> 1;
                state_next = rmss_pkg::ST_Q_RD;
            end
            rmss_pkg::ST_WALK_RD:
            begin
                state_next = rmss_pkg::ST_WALK;
            end
            rmss_pkg::ST_WALK:
            begin
                state_next = rmss_pkg::ST_OUT;
                if (bsum_reg[bkt_reg] == '0)
                begin
                    if (!lo_is && 32'(bkt_reg) != BUCKET_COUNT - 1)
                    begin
                        bkt_next   = bkt_reg + BW'(1);
                        state_next = rmss_pkg::ST_WALK;
                    end
                end
                else if (!(lo_is && ans_reg < OW'(bmin_reg[bkt_reg])))
                begin
                    ans_next = ans_reg + OW'(bsum_reg[bkt_reg]);
                    if (32'(bkt_reg) != BUCKET_COUNT - 1)
                    begin
                        bkt_next   = bkt_reg + BW'(1);
                        state_next = rmss_pkg::ST_WALK;
                    end
                end
            end
            rmss_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = rmss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rmss_pkg::ST_IDLE;
            end
        endcase
    end

    `RMSS_ASSERT(a_out_nonzero, clk, rst_n, out_valid |-> smallest_missing != '0, "zero answer")
    `RMSS_ASSERT(a_no_take_busy, clk, rst_n, out_valid |-> in_stall, "input open during result")
    `RMSS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(smallest_missing), "result dropped")
endmodule
`default_nettype wire

### tb/tb_range_missing_subset_sum.sv
`timescale 1ns / 1ps
`default_nettype none

// Self-checking bench for the range smallest-missing-subset-sum block.
// Writes and queries go through a valid/stall sender, and each query result
// is checked against a behavioural model held here. The model keeps a flat
// array of elements and rebuilds the bucket minima and sums for every query.
module tb_range_missing_subset_sum;

    localparam int unsigned ELEMENTS   = 1024;
    localparam int unsigned BUCKETS    = 32;
    // No word is taken during the clearing pass, so the
    // watchdog limit has to sit well above its length.
    localparam int unsigned STALL_LIMIT = 300000;
    // Slowest word is a query.
    localparam int unsigned TAIL_CYCLES = 3000;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic                                action;
    logic [rmss_pkg::PosWidth-1:0]       position;
    logic [rmss_pkg::ValueWidth-1:0]     element_value;
    logic [rmss_pkg::PosWidth-1:0]       range_low;
    logic [rmss_pkg::PosWidth-1:0]       range_high;
    logic                                out_valid;
    logic                                out_stall;
    logic [rmss_pkg::OutWidth-1:0]       smallest_missing;

    // Local copy of the element array, index 1..ELEMENTS
    logic [rmss_pkg::ValueWidth-1:0] element_mirror [1:ELEMENTS];
    // Answers still owed by the block, oldest first
    logic [rmss_pkg::OutWidth-1:0]   answer_queue [$];

    int unsigned error_count;
    int unsigned writes_sent;
    int unsigned queries_sent;
    int unsigned answers_checked;
    int unsigned quiet_cycles;
    bit          idle_enable;

    range_missing_subset_sum #(
        .ELEMENT_COUNT(ELEMENTS),
        .BUCKET_COUNT (BUCKETS)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .position        (position),
        .element_value   (element_value),
        .range_low       (range_low),
        .range_high      (range_high),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .smallest_missing(smallest_missing)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Greedy bucket walk over the clamped range, from a running answer of 1.
    function automatic logic [rmss_pkg::OutWidth-1:0] missing_sum(
        input logic [rmss_pkg::PosWidth-1:0] lo_in,
        input logic [rmss_pkg::PosWidth-1:0] hi_in);
        logic [31:0] lo;
        logic [31:0] hi;
        logic [63:0] ans;
        logic [63:0] bsum [BUCKETS];
        logic [31:0] bmin [BUCKETS];
        logic [31:0] v;
        logic        below;
        int          top;
        lo = (lo_in < 1) ? 32'd1 : 32'(lo_in);
        hi = (hi_in > ELEMENTS) ? 32'(ELEMENTS) : 32'(hi_in);
        if (lo > hi)
        begin
            return rmss_pkg::OutWidth'(1);
        end
        for (int i = 0; i < BUCKETS; i++)
        begin
            bsum[i] = '0;
            bmin[i] = '1;
        end
        for (int p = lo; p <= hi; p++)
        begin
            v = element_mirror[p];
            if (v != 0)
            begin
                top = 0;
                for (int b = 0; b < 32; b++)
                begin
                    if (v[b])
                    begin
                        top = b;
                    end
                end
                bsum[top] += 64'(v);
                if (v < bmin[top])
                begin
                    bmin[top] = v;
                end
            end
        end
        ans = 64'd1;
        for (int i = 0; i < BUCKETS; i++)
        begin
            below = (i + 1 >= 63) ? 1'b1 : (ans < (64'd1 << (i + 1)));
            if (bsum[i] == 0)
            begin
                if (below)
                begin
                    break;
                end
                continue;
            end
            if (below && ans < 64'(bmin[i]))
            begin
                break;
            end
            ans += bsum[i];
        end
        return ans[rmss_pkg::OutWidth-1:0];
    endfunction

    // Present one word, hold it until taken, then update the model.
    task automatic send_word(input logic                            act,
                             input logic [rmss_pkg::PosWidth-1:0]   pos,
                             input logic [rmss_pkg::ValueWidth-1:0] val,
                             input logic [rmss_pkg::PosWidth-1:0]   lo,
                             input logic [rmss_pkg::PosWidth-1:0]   hi);
        logic taken;
        while (idle_enable && $urandom_range(0, 99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        action        <= act;
        position      <= pos;
        element_value <= val;
        range_low     <= lo;
        range_high    <= hi;
        // stall is settled mid-cycle, so sample it there for the coming edge
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        if (act == rmss_pkg::ActWrite)
        begin
            writes_sent++;
            if (pos >= 1 && pos <= ELEMENTS)
            begin
                element_mirror[pos] = val;
            end
        end
        else
        begin
            queries_sent++;
            answer_queue.push_back(missing_sum(lo, hi));
        end
    endtask

    task automatic write_element(input logic [rmss_pkg::PosWidth-1:0] pos,
                                 input logic [rmss_pkg::ValueWidth-1:0] val);
        send_word(rmss_pkg::ActWrite, pos, val, rmss_pkg::PosWidth'($urandom),
                  rmss_pkg::PosWidth'($urandom));
    endtask

    task automatic ask_range(input logic [rmss_pkg::PosWidth-1:0] lo,
                             input logic [rmss_pkg::PosWidth-1:0] hi);
        send_word(rmss_pkg::ActQuery, rmss_pkg::PosWidth'($urandom), $urandom, lo, hi);
    endtask

    task automatic wait_for_answers();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (answer_queue.size() != 0);
    endtask

    function automatic logic [rmss_pkg::ValueWidth-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
        begin
            return rmss_pkg::ValueWidth'($urandom_range(1, 16));
        end
        else if (sel < 75)
        begin
            return $urandom >> $urandom_range(0, 31);
        end
        else if (sel < 85)
        begin
            return '0;
        end
        return rmss_pkg::ValueWidth'(1) << $urandom_range(0, 31);
    endfunction

    function automatic logic [rmss_pkg::PosWidth-1:0] pick_position();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            return rmss_pkg::PosWidth'($urandom_range(1, 64));
        end
        else if (sel < 95)
        begin
            return rmss_pkg::PosWidth'($urandom_range(1, ELEMENTS));
        end
        return rmss_pkg::PosWidth'($urandom);
    endfunction

    // Bounds, clamping, ignored writes and the corner walks.
    task automatic test_directed();
        ask_range(1, 1024);                       // empty array
        ask_range(5, 3);                          // low above high
        ask_range(0, 2047);                       // both bounds clamped
        write_element(0, 32'd7);                  // ignored positions
        write_element(1025, 32'd7);
        write_element(2047, 32'hFFFF_FFFF);
        ask_range(0, 2047);
        write_element(1, 32'd1);
        write_element(2, 32'd2);
        write_element(3, 32'd4);
        write_element(512, 32'h8000_0000);
        write_element(1024, 32'hFFFF_FFFF);
        ask_range(1, 3);                          // dense run: 8
        ask_range(2, 3);                          // no 1: answer 1
        ask_range(1, 1024);
        ask_range(1024, 1024);
        ask_range(1025, 2047);                    // empty after clamp
        write_element(2, 32'd0);                  // zero deletes
        ask_range(1, 3);                          // empty bucket stops walk
        write_element(4, 32'd3);
        write_element(5, 32'd7);
        ask_range(1, 5);
        ask_range(3, 3);
        wait_for_answers();                       // sender holds off fully
    endtask

    task automatic test_random_mix(input int unsigned count);
        logic [rmss_pkg::PosWidth-1:0] lo;
        int unsigned sel;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                write_element(pick_position(), pick_value());
            end
            else
            begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                begin
                    lo = rmss_pkg::PosWidth'($urandom_range(1, 64));
                    ask_range(lo, lo + rmss_pkg::PosWidth'($urandom_range(0, 64)));
                end
                else if (sel < 90)
                begin
                    ask_range(rmss_pkg::PosWidth'($urandom_range(1, ELEMENTS)),
                              rmss_pkg::PosWidth'($urandom_range(1, ELEMENTS)));
                end
                else
                begin
                    ask_range(rmss_pkg::PosWidth'($urandom), rmss_pkg::PosWidth'($urandom));
                end
            end
        end
    endtask

    task automatic test_no_idle(input int unsigned count);
        idle_enable = 1'b0;
        test_random_mix(count);
        idle_enable = 1'b1;
    endtask

    // Result side: random stall, driven at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= idle_enable && ($urandom_range(0, 99) < 17);
        end
    end

    // In-order compare against the model, sampled mid-cycle for the coming edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (answer_queue.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %0d",
                             $time, smallest_missing);
                    error_count++;
                end
                else
                begin
                    if (smallest_missing !== answer_queue[0])
                    begin
                        $display("%0t: smallest_missing expected %0d, actual %0d",
                                 $time, answer_queue[0], smallest_missing);
                        error_count++;
                    end
                    answer_queue.pop_front();
                    answers_checked++;
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(negedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb_range_missing_subset_sum failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = 1'b0;
        position      = '0;
        element_value = '0;
        range_low     = '0;
        range_high    = '0;
        out_stall     = 1'b0;
        error_count   = 0;
        writes_sent   = 0;
        queries_sent  = 0;
        answers_checked = 0;
        quiet_cycles  = 0;
        idle_enable   = 1'b1;
        for (int p = 1; p <= ELEMENTS; p++)
        begin
            element_mirror[p] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(700);
        test_no_idle(200);
        test_random_mix(300);

        wait_for_answers();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d writes and %0d range queries, %0d answers compared.",
                 writes_sent, queries_sent, answers_checked);
        if (error_count == 0 && answer_queue.size() == 0)
        begin
            $display("tb_range_missing_subset_sum passed");
        end
        else
        begin
            $display("tb_range_missing_subset_sum failed");
        end
        $finish;
    end
endmodule

`default_nettype wire
